### rtl/mss_pkg.sv
package mss_pkg;

	// request codes carried by req_type
	typedef enum logic [2:0] {
		REQ_TICK    = 3'd0,
		REQ_STEPS   = 3'd1,
		REQ_DEGREES = 3'd2,
		REQ_CONT    = 3'd3,
		REQ_STOP    = 3'd4
	} req_t;

	localparam int unsigned FULL_STEPS_PER_REV = 512;
	localparam int unsigned TABLE_STEPS        = 64;
	localparam int unsigned PHASE_W            = $clog2(TABLE_STEPS);

	localparam int unsigned DEG_W     = 16;
	// degrees times steps per rev stays below 2**29 over the whole 16-bit range of degrees
	localparam int unsigned PROD_W    = 29;
	// divide by 360 as a shift by 3 and an exact reciprocal multiply for 45
	localparam int unsigned X_W       = PROD_W - 3;
	localparam int unsigned RECIP_W   = 32;
	localparam logic [RECIP_W-1:0] DIV45_MUL = 32'd3054198967;
	localparam int unsigned DIV45_SHIFT = 37;
	localparam int unsigned QF_W      = X_W + RECIP_W;
	localparam int unsigned Q_W       = QF_W - DIV45_SHIFT;

	localparam logic [15:0] STEP_RELOAD_RST = 16'd999;

	// item handed from the goal stages to the sequencer core
	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] amount;
		logic        direction;
		logic [31:0] deg_goal;
	} mss_item_t;

	// coil duties per microstep row, packed as {a, b, c, d}
	localparam logic [31:0] COIL_TABLE [0:TABLE_STEPS-1] = '{
		32'hFF000000, 32'hFD180000, 32'hFA310000, 32'hF44A0000,
		32'hEB610000, 32'hE0780000, 32'hD48D0000, 32'hC5A10000,
		32'hB4B40000, 32'hA1C50000, 32'h8DD40000, 32'h78E00000,
		32'h61EB0000, 32'h4AF40000, 32'h31FA0000, 32'h18FD0000,
		32'h00FF0000, 32'h00FE1900, 32'h00FA3200, 32'h00F44A00,
		32'h00EC6200, 32'h00E17800, 32'h00D48E00, 32'h00C5A200,
		32'h00B4B400, 32'h00A2C500, 32'h008ED400, 32'h0078E100,
		32'h0062EC00, 32'h004AF400, 32'h0032FA00, 32'h0019FE00,
		32'h0000FF00, 32'h0000FE19, 32'h0000FA32, 32'h0000F44A,
		32'h0000EC62, 32'h0000E178, 32'h0000D48E, 32'h0000C5A2,
		32'h0000B4B4, 32'h0000A2C5, 32'h00008ED4, 32'h000078E1,
		32'h000062EC, 32'h00004AF4, 32'h000032FA, 32'h000019FE,
		32'h000000FF, 32'h190000FE, 32'h320000FA, 32'h4A0000F4,
		32'h620000EC, 32'h780000E1, 32'h8E0000D4, 32'hA20000C5,
		32'hB40000B4, 32'hC50000A2, 32'hD400008E, 32'hE1000078,
		32'hEC000062, 32'hF400004A, 32'hFA000032, 32'hFE000019
	};

endpackage

### rtl/microstep_stepper_sequencer_top.sv
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// input    | in_valid/in_stall  | req_type, amount, direction
// output   | out_valid/out_stall| duty_a..duty_d, phase, running, stepped
// config   | step_reload_we     | step_reload
//
// one item per clock sustained while out_stall stays low; out_valid rises once the item has passed
// (goal stage one, goal stage two with the degree scaling, then the result register)
// arst_n clears all valid bits and the sequencer state, reload returns to 999
// a stalled result holds; upstream stages keep filling until every stage is full
module microstep_stepper_sequencer_top
	import mss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_reload_we,
	input  logic [15:0] step_reload,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] amount,
	input  logic        direction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty_a,
	output logic [7:0]  duty_b,
	output logic [7:0]  duty_c,
	output logic [7:0]  duty_d,
	output logic [5:0]  phase,
	output logic        running,
	output logic        stepped
);

	logic      core_ready;
	logic      item_valid;
	mss_item_t item;

	// degree goal stages
	mss_goal u_goal (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.amount     (amount),
		.direction  (direction),
		.core_ready (core_ready),
		.item_valid (item_valid),
		.item       (item)
	);

	// sequencer state and result register
	mss_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_reload_we (step_reload_we),
		.step_reload    (step_reload),
		.item_valid     (item_valid),
		.item           (item),
		.core_ready     (core_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.duty_a         (duty_a),
		.duty_b         (duty_b),
		.duty_c         (duty_c),
		.duty_d         (duty_d),
		.phase          (phase),
		.running        (running),
		.stepped        (stepped)
	);

endmodule

### rtl/mss_goal.sv
module mss_goal
	import mss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [31:0]       amount,
	input  logic              direction,
	input  logic              core_ready,
	output logic              item_valid,
	output mss_item_t         item
);

	logic              valid_s1;
	logic [2:0]        req_type_s1;
	logic [31:0]       amount_s1;
	logic              direction_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              valid_s2;
	mss_item_t         item_s2;
	logic              en_s1;
	logic              en_s2;
	logic [PROD_W-1:0] prod_d;
	logic [X_W-1:0]    x_val;
	logic [QF_W-1:0]   q_full;
	logic [Q_W-1:0]    q_val;

	// stage enables, a stage moves when empty or when its successor moves
	assign en_s2    = !valid_s2 || core_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// degrees times steps per revolution
	assign prod_d = PROD_W'(32'(amount[DEG_W-1:0]) * 32'(FULL_STEPS_PER_REV));

	// divide by 360 then scale by 8
	assign x_val  = prod_s1[PROD_W-1:3];
	assign q_full = QF_W'(x_val) * QF_W'(DIV45_MUL);
	assign q_val  = q_full[QF_W-1:DIV45_SHIFT];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_type_s1  <= req_type;
			amount_s1    <= amount;
			direction_s1 <= direction;
			prod_s1      <= prod_d;
		end
		if (en_s2) begin
			item_s2.req_type  <= req_type_s1;
			item_s2.amount    <= amount_s1;
			item_s2.direction <= direction_s1;
			item_s2.deg_goal  <= 32'({q_val, 3'b000});
		end
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;

endmodule

### rtl/mss_core.sv
module mss_core
	import mss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_reload_we,
	input  logic [15:0]  step_reload,
	input  logic         item_valid,
	input  mss_item_t    item,
	output logic         core_ready,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   duty_a,
	output logic [7:0]   duty_b,
	output logic [7:0]   duty_c,
	output logic [7:0]   duty_d,
	output logic [5:0]   phase,
	output logic         running,
	output logic         stepped
);

	logic [15:0]        reload_q;
	logic               running_q;
	logic [31:0]        count_q;
	logic [31:0]        goal_q;
	logic               reverse_q;
	logic [15:0]        tick_q;
	logic [PHASE_W-1:0] phase_q;
	logic               energized_q;
	logic               out_valid_q;
	logic [31:0]        duty_q;
	logic [PHASE_W-1:0] phase_out_q;
	logic               running_out_q;
	logic               stepped_q;

	logic               running_d;
	logic [31:0]        count_d;
	logic [31:0]        goal_d;
	logic               reverse_d;
	logic [15:0]        tick_d;
	logic [PHASE_W-1:0] phase_d;
	logic               energized_d;
	logic               stepped_d;
	logic [31:0]        count_inc;
	logic               take;

	assign core_ready = !out_valid_q || !out_stall;
	assign take       = item_valid && core_ready;
	assign count_inc  = count_q + 32'd1;

	// next state for one request
	always_comb begin
		running_d   = running_q;
		count_d     = count_q;
		goal_d      = goal_q;
		reverse_d   = reverse_q;
		tick_d      = tick_q;
		phase_d     = phase_q;
		energized_d = energized_q;
		stepped_d   = 1'b0;
		unique case (req_t'(item.req_type))
			REQ_TICK: begin
				if (running_q) begin
					if (tick_q >= reload_q) begin
						// one microstep, row mirrored when reversed
						tick_d      = 16'd0;
						phase_d     = count_q[PHASE_W-1:0] ^ {PHASE_W{reverse_q}};
						energized_d = 1'b1;
						count_d     = count_inc;
						stepped_d   = 1'b1;
						if (goal_q != 32'd0 && count_inc >= goal_q) begin
							running_d = 1'b0;
						end
					end else begin
						tick_d = tick_q + 16'd1;
					end
				end
			end
			REQ_STEPS: begin
				count_d   = 32'd0;
				goal_d    = item.amount;
				reverse_d = item.direction;
				running_d = 1'b1;
			end
			REQ_DEGREES: begin
				count_d   = 32'd0;
				goal_d    = item.deg_goal;
				reverse_d = item.direction;
				running_d = 1'b1;
			end
			REQ_CONT: begin
				count_d   = 32'd0;
				goal_d    = 32'd0;
				reverse_d = item.direction;
				running_d = 1'b1;
			end
			REQ_STOP: begin
				running_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// sequencer state and reload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q    <= STEP_RELOAD_RST;
			running_q   <= 1'b0;
			count_q     <= 32'd0;
			goal_q      <= 32'd0;
			reverse_q   <= 1'b0;
			tick_q      <= 16'd0;
			phase_q     <= '0;
			energized_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_reload_we) begin
				reload_q <= step_reload;
			end
			if (take) begin
				running_q   <= running_d;
				count_q     <= count_d;
				goal_q      <= goal_d;
				reverse_q   <= reverse_d;
				tick_q      <= tick_d;
				phase_q     <= phase_d;
				energized_q <= energized_d;
			end
			if (core_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	// result register, duties from the sine table
	always_ff @(posedge clk) begin
		if (take) begin
			duty_q        <= energized_d ? COIL_TABLE[phase_d] : 32'd0;
			phase_out_q   <= phase_d;
			running_out_q <= running_d;
			stepped_q     <= stepped_d;
		end
	end

	assign out_valid = out_valid_q;
	assign duty_a    = duty_q[31:24];
	assign duty_b    = duty_q[23:16];
	assign duty_c    = duty_q[15:8];
	assign duty_d    = duty_q[7:0];
	assign phase     = 6'(phase_out_q);
	assign running   = running_out_q;
	assign stepped   = stepped_q;

endmodule

### verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mss_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT = 150000;
	localparam int PHASE_ITEMS = 88;
	localparam int RANDOM_PHASES = 8;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 8;

	// request codes that the block must ignore
	localparam logic [2:0] REQ_SPARE_LO = 3'(REQ_STOP + 1);
	localparam logic [2:0] REQ_SPARE_HI = '1;

	// coil duties per microstep row, {a, b, c, d}
	localparam logic [31:0] COIL_ROWS [TABLE_STEPS] = '{
		32'hFF000000, 32'hFD180000, 32'hFA310000, 32'hF44A0000,
		32'hEB610000, 32'hE0780000, 32'hD48D0000, 32'hC5A10000,
		32'hB4B40000, 32'hA1C50000, 32'h8DD40000, 32'h78E00000,
		32'h61EB0000, 32'h4AF40000, 32'h31FA0000, 32'h18FD0000,
		32'h00FF0000, 32'h00FE1900, 32'h00FA3200, 32'h00F44A00,
		32'h00EC6200, 32'h00E17800, 32'h00D48E00, 32'h00C5A200,
		32'h00B4B400, 32'h00A2C500, 32'h008ED400, 32'h0078E100,
		32'h0062EC00, 32'h004AF400, 32'h0032FA00, 32'h0019FE00,
		32'h0000FF00, 32'h0000FE19, 32'h0000FA32, 32'h0000F44A,
		32'h0000EC62, 32'h0000E178, 32'h0000D48E, 32'h0000C5A2,
		32'h0000B4B4, 32'h0000A2C5, 32'h00008ED4, 32'h000078E1,
		32'h000062EC, 32'h00004AF4, 32'h000032FA, 32'h000019FE,
		32'h000000FF, 32'h190000FE, 32'h320000FA, 32'h4A0000F4,
		32'h620000EC, 32'h780000E1, 32'h8E0000D4, 32'hA20000C5,
		32'hB40000B4, 32'hC50000A2, 32'hD400008E, 32'hE1000078,
		32'hEC000062, 32'hF400004A, 32'hFA000032, 32'hFE000019
	};

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] amt;
		logic        dir;
	} stepper_req_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [5:0] row;
		logic       run;
		logic       stp;
	} coil_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        step_reload_we = 1'b0;
	logic [15:0] step_reload = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = REQ_TICK;
	logic [31:0] amount = '0;
	logic        direction = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  duty_a;
	logic [7:0]  duty_b;
	logic [7:0]  duty_c;
	logic [7:0]  duty_d;
	logic [5:0]  phase;
	logic        running;
	logic        stepped;

	// sequencer state as the testbench expects it
	logic [15:0] seq_reload = STEP_RELOAD_RST;
	logic        seq_run = 1'b0;
	logic [31:0] seq_count = '0;
	logic [31:0] seq_goal = '0;
	logic        seq_rev = 1'b0;
	logic [15:0] seq_ticks = '0;
	logic [5:0]  seq_row = '0;
	logic        seq_lit = 1'b0;

	stepper_req_t req_backlog[$];
	coil_out_t    coil_expect[$];

	logic took_item = 1'b0;
	int   gap_left = 0;
	int   hold_left = 0;
	int   idle_max = 3;
	int   cycle_count = 0;
	int   errors = 0;
	int   mismatches = 0;
	int   queued_items = 0;
	int   results_checked = 0;
	int   step_total = 0;
	int   goal_stops = 0;
	int   reload_writes = 0;

	microstep_stepper_sequencer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_reload_we(step_reload_we),
		.step_reload   (step_reload),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.amount        (amount),
		.direction     (direction),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.duty_a        (duty_a),
		.duty_b        (duty_b),
		.duty_c        (duty_c),
		.duty_d        (duty_d),
		.phase         (phase),
		.running       (running),
		.stepped       (stepped)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// apply one request item to the expected state and return the coil result
	function automatic coil_out_t advance_sequencer(logic [2:0] kind, logic [31:0] amt,
		logic dir);
		coil_out_t   r;
		logic        launch;
		logic [31:0] new_goal;
		logic [31:0] scaled;
		logic [5:0]  row;
		logic [31:0] duties;
		r = '0;
		launch = 1'b0;
		new_goal = '0;
		case (kind)
			REQ_TICK: begin
				if (seq_run) begin
					if (seq_ticks >= seq_reload) begin
						seq_ticks = '0;
						row = seq_count[5:0];
						if (seq_rev)
							row = 6'(TABLE_STEPS - 1) - row;
						seq_row = row;
						seq_lit = 1'b1;
						seq_count = seq_count + 32'd1;
						r.stp = 1'b1;
						step_total++;
						if (seq_goal != '0 && seq_count >= seq_goal) begin
							seq_run = 1'b0;
							goal_stops++;
						end
					end else begin
						seq_ticks = seq_ticks + 16'd1;
					end
				end
			end
			REQ_STEPS: begin
				launch = 1'b1;
				new_goal = amt;
			end
			REQ_DEGREES: begin
				// only the low 16 bits carry degrees
				scaled = 32'(amt[15:0]) * 32'(FULL_STEPS_PER_REV);
				new_goal = (scaled / 32'd360) * 32'd8;
				launch = 1'b1;
			end
			REQ_CONT: begin
				launch = 1'b1;
			end
			REQ_STOP: begin
				seq_run = 1'b0;
			end
			default: ;
		endcase
		// rotate requests keep the tick counter
		if (launch) begin
			seq_count = '0;
			seq_goal = new_goal;
			seq_rev = dir;
			seq_run = 1'b1;
		end
		duties = seq_lit ? COIL_ROWS[seq_row] : '0;
		{r.a, r.b, r.c, r.d} = duties;
		r.row = seq_row;
		r.run = seq_run;
		return r;
	endfunction

	// request driver, one item at a time from the backlog
	always @(negedge clk) begin : feed_requests
		stepper_req_t nxt;
		if (arst_n && (!in_valid || took_item)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				nxt = req_backlog.pop_front();
				req_type <= nxt.kind;
				amount <= nxt.amt;
				direction <= nxt.dir;
				in_valid <= 1'b1;
				gap_left = $urandom_range(0, idle_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// check results in order, then predict for the accepted request
	always @(posedge clk) begin : check_results
		coil_out_t seen;
		coil_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = {duty_a, duty_b, duty_c, duty_d, phase, running, stepped};
				results_checked++;
				if (coil_expect.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("cycle %0d: result with nothing expected: duty %0d/%0d/%0d/%0d",
							cycle_count, seen.a, seen.b, seen.c, seen.d);
				end else begin
					want = coil_expect.pop_front();
					if (seen !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("cycle %0d: expected duty %0d/%0d/%0d/%0d phase %0d run %0b step %0b",
								cycle_count, want.a, want.b, want.c, want.d,
								want.row, want.run, want.stp);
							$display("cycle %0d: got duty %0d/%0d/%0d/%0d phase %0d run %0b step %0b",
								cycle_count, seen.a, seen.b, seen.c, seen.d,
								seen.row, seen.run, seen.stp);
						end
					end
				end
				hold_left = $urandom_range(0, idle_max);
			end
			if (in_valid && !in_stall)
				coil_expect.push_back(advance_sequencer(req_type, amount, direction));
			took_item <= in_valid && !in_stall;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("no progress, stopped after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_item(logic [2:0] kind, logic [31:0] amt, logic dir);
		stepper_req_t it;
		it.kind = kind;
		it.amt = amt;
		it.dir = dir;
		req_backlog.push_back(it);
		queued_items++;
	endtask

	task automatic queue_ticks(int n);
		for (int i = 0; i < n; i++)
			queue_item(REQ_TICK, $urandom(), 1'($urandom()));
	endtask

	// wait until every item went through and every result came back
	task automatic drain();
		while (req_backlog.size() != 0 || in_valid || coil_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_reload(logic [15:0] value);
		step_reload_we <= 1'b1;
		step_reload <= value;
		seq_reload = value;
		reload_writes++;
		@(negedge clk);
		step_reload_we <= 1'b0;
	endtask

	// one rotate command with ticks after it, or a short run of noise
	task automatic queue_burst();
		int          pick;
		logic [31:0] goal;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			case ($urandom_range(0, 3))
				0: begin
					goal = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 80);
					queue_item(REQ_STEPS, goal, 1'($urandom()));
				end
				1: begin
					goal = ($urandom_range(0, 3) == 0) ? $urandom()
						: {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))};
					queue_item(REQ_DEGREES, goal, 1'($urandom()));
				end
				2: queue_item(REQ_CONT, $urandom(), 1'($urandom()));
				default: queue_item(REQ_STEPS, $urandom_range(1, 4), 1'($urandom()));
			endcase
			queue_ticks($urandom_range(3, 30));
			if ($urandom_range(0, 2) == 0)
				queue_item(REQ_STOP, $urandom(), 1'($urandom()));
		end else begin
			repeat ($urandom_range(1, 4))
				queue_item(3'($urandom_range(0, REQ_SPARE_HI)), $urandom(), 1'($urandom()));
		end
	endtask

	initial begin : stimulus
		int target;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset reload: ignored requests while stopped, rotate setup at range ends
		queue_item(REQ_TICK, '1, 1'b1);
		queue_item(REQ_SPARE_LO, '1, 1'b1);
		queue_item(REQ_SPARE_HI, '0, 1'b0);
		queue_item(REQ_STOP, '1, 1'b1);
		queue_item(REQ_DEGREES, '1, 1'b1);
		queue_ticks(1);
		queue_item(REQ_STEPS, '1, 1'b0);
		queue_item(REQ_STOP, '0, 1'b0);
		drain();

		// step on every tick: goal of one, degree goal, rotate while running
		set_reload('0);
		queue_item(REQ_STEPS, 32'd1, 1'b0);
		queue_ticks(2);
		queue_item(REQ_DEGREES, 32'd1, 1'b1);
		queue_ticks(9);
		queue_item(REQ_CONT, '0, 1'b1);
		queue_ticks(1);
		queue_item(REQ_STEPS, 32'd3, 1'b0);
		queue_ticks(1);
		queue_item(REQ_STOP, '0, 1'b0);
		drain();

		// slowest reload, then a lower one below the tick count steps at once
		set_reload('1);
		queue_item(REQ_CONT, '0, 1'b0);
		queue_ticks(4);
		drain();
		set_reload(16'd3);
		queue_ticks(1);
		queue_item(REQ_STOP, '0, 1'b0);
		drain();

		// random phases, mostly short reloads so runs reach their goals
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_max = (ph % 3 == 2) ? 0 : 3;
			case (ph % 4)
				0: set_reload('0);
				1: set_reload(16'd1);
				2: set_reload(16'($urandom_range(2, 3)));
				default: set_reload(16'($urandom_range(0, 12)));
			endcase
			target = queued_items + PHASE_ITEMS;
			while (queued_items < target)
				queue_burst();
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (coil_expect.size() != 0) begin
			errors += coil_expect.size();
			$display("%0d expected results never arrived", coil_expect.size());
		end
		$display("%0d request items under %0d reload writes, %0d results checked",
			queued_items, reload_writes, results_checked);
		$display("%0d microsteps taken, %0d runs ended on their goal, %0d mismatches",
			step_total, goal_stops, mismatches);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
